### hdl/pa_power_calibration_interp_core_macros.svh
// Assertion helpers shared by the calibration core.
`ifndef PA_POWER_CALIBRATION_INTERP_CORE_MACROS_SVH
`define PA_POWER_CALIBRATION_INTERP_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PCAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition at one edge that implies a consequence at the next edge.
`define PCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

### hdl/pcal_pkg.sv
package pcal_pkg;

	localparam int DbmW  = 8;
	localparam int PointW = 24;
	localparam int PairW  = 48;
	localparam int NumW   = 16;
	localparam int DenW   = 8;
	localparam int DiffW  = 9;
	localparam int ProdW  = 18;

	// One calibration point as packed in a pair register, lowest field in the lowest bits.
	typedef struct packed {
		logic [DbmW-1:0]        dac;
		logic signed [DbmW-1:0] drive;
		logic [DbmW-1:0]        out_dbm;
	} point_t;

	typedef enum logic [2:0] {
		REG_CAL_PAIR_0  = 3'd0,
		REG_CAL_PAIR_1  = 3'd1,
		REG_CAL_PAIR_2  = 3'd2,
		REG_MIN_OUT_DBM = 3'd3,
		REG_MAX_OUT_DBM = 3'd4,
		REG_CLAMP_EN    = 3'd5
	} cfg_reg_t;

	// Side information that rides alongside the division.
	typedef struct packed {
		logic            acc;
		logic [DbmW-1:0] applied;
		logic [DbmW-1:0] y0_drive;
		logic [DbmW-1:0] y0_dac;
		logic            flat;
		logic            neg_drive;
		logic            neg_dac;
	} div_tag_t;

	typedef struct packed {
		div_tag_t        tag;
		logic [NumW-1:0] num_drive;
		logic [NumW-1:0] num_dac;
		logic [DenW-1:0] den;
	} div_job_t;

	typedef struct packed {
		div_tag_t        tag;
		logic [NumW-1:0] quo_drive;
		logic [NumW-1:0] quo_dac;
	} div_res_t;

endpackage

### hdl/pa_power_calibration_interp_core.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata: target_dbm
// m_axis    out        tdata: applied_dbm, drive_dbm, dac_code; tuser: accepted
// cfg       in         cfg_index selects the register, cfg_data carries the value
//
// A target beat is taken every cycle when the output side keeps up. The beat passes
// 21 register stages: the restoring divider resolves one quotient bit per stage over
// 16 stages, and five other stages lie around it, the first of which captures the beat
// at the accepting edge.
// Reset clears every valid bit and returns the configuration registers to their reset values.
// Each stage holds while the one after it is full and stalled, so a stall on
// m_axis fills bubbles first and only then pushes back on s_axis.
`include "pa_power_calibration_interp_core_macros.svh"

module pa_power_calibration_interp_core #(
	parameter int CAL_POINTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] target_dbm
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] applied_dbm, [15:8] drive_dbm, [23:16] dac_code
	output logic        m_axis_tuser,   // [0] accepted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	// Only as many pair registers as the calibration points need are kept.
	localparam int Pairs = (CAL_POINTS + 1) / 2;

	logic [pcal_pkg::PairW-1:0] cal_pair_q [Pairs];
	logic [pcal_pkg::DbmW-1:0]  min_dbm_q, max_dbm_q;
	logic                       clamp_en_q;
	logic                       cfg_fire;

	pcal_pkg::point_t pts [CAL_POINTS];

	logic                      vld_s1, acc_s1;
	logic [pcal_pkg::DbmW-1:0] t_s1;
	logic                      in_fire, rdy_s1, prep_ready;

	logic                      div_in_valid, div_in_ready;
	pcal_pkg::div_job_t        div_job;
	logic                      div_out_valid, div_out_ready;
	pcal_pkg::div_res_t        div_res;

	logic                      vld_s21, acc_s21;
	logic [pcal_pkg::DbmW-1:0] app_s21, drv_s21, dac_s21;

	logic [pcal_pkg::DbmW-1:0] t_in, t_lo, t_hi, qd, qa, drv_nx, dac_nx;
	logic                      below, above, reject;

	// ------------------------------------------------------------------
	// Configuration registers. The write channel never stalls.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	for (genvar p = 0; p < Pairs; p++) begin : g_pair
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cal_pair_q[p] <= '0;
			end else if (cfg_fire &&
			             cfg_index == 3'(int'(pcal_pkg::REG_CAL_PAIR_0) + p)) begin
				cal_pair_q[p] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dbm_q  <= 8'd20;
			max_dbm_q  <= 8'd30;
			clamp_en_q <= 1'b1;
		end else if (cfg_fire) begin
			case (cfg_index)
				pcal_pkg::REG_MIN_OUT_DBM: min_dbm_q  <= cfg_data[7:0];
				pcal_pkg::REG_MAX_OUT_DBM: max_dbm_q  <= cfg_data[7:0];
				pcal_pkg::REG_CLAMP_EN:    clamp_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Point i sits in the low or high half of pair i/2.
	for (genvar i = 0; i < CAL_POINTS; i++) begin : g_pt
		assign pts[i] = pcal_pkg::point_t'(
			cal_pair_q[i/2][(i%2)*pcal_pkg::PointW +: pcal_pkg::PointW]);
	end

	// ------------------------------------------------------------------
	// Stage 1: range check and clamping. The low bound is applied before
	// the high bound, so with the bounds crossed a clamped target ends at
	// the high bound.
	// ------------------------------------------------------------------
	assign t_in   = s_axis_tdata;
	assign below  = t_in < min_dbm_q;
	assign t_lo   = below ? min_dbm_q : t_in;
	assign above  = t_lo > max_dbm_q;
	assign t_hi   = above ? max_dbm_q : t_lo;
	assign reject = !clamp_en_q && (below || above);

	assign rdy_s1        = !vld_s1 || prep_ready;
	assign s_axis_tready = rdy_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_s1 <= !reject;
			t_s1   <= t_hi;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 4: segment search, products, sign split.
	// ------------------------------------------------------------------
	pcal_prep #(
		.CAL_POINTS(CAL_POINTS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts       (pts),
		.in_valid  (vld_s1),
		.in_ready  (prep_ready),
		.in_acc    (acc_s1),
		.in_t      (t_s1),
		.out_valid (div_in_valid),
		.out_ready (div_in_ready),
		.out_job   (div_job)
	);

	// ------------------------------------------------------------------
	// Stages 5 to 20: unsigned restoring division of both products by the
	// segment span.
	// ------------------------------------------------------------------
	pcal_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_in_valid),
		.in_ready  (div_in_ready),
		.in_job    (div_job),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_res   (div_res)
	);

	// ------------------------------------------------------------------
	// Stage 21: the output register. The quotient takes its sign back
	// (truncation toward zero falls out of dividing magnitudes), and is
	// added to the lower point. Only the low byte is kept, so the sums run
	// modulo 256. A zero span returns the lower point unchanged, and a
	// rejected request gives all zeros.
	// ------------------------------------------------------------------
	assign qd = div_res.tag.neg_drive ? 8'(8'd0 - div_res.quo_drive[7:0])
	                                  : div_res.quo_drive[7:0];
	assign qa = div_res.tag.neg_dac   ? 8'(8'd0 - div_res.quo_dac[7:0])
	                                  : div_res.quo_dac[7:0];

	assign drv_nx = div_res.tag.flat ? div_res.tag.y0_drive
	                                 : 8'(div_res.tag.y0_drive + qd);
	assign dac_nx = div_res.tag.flat ? div_res.tag.y0_dac
	                                 : 8'(div_res.tag.y0_dac + qa);

	assign div_out_ready = !vld_s21 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s21 <= 1'b0;
		end else if (div_out_ready) begin
			vld_s21 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready && div_out_valid) begin
			acc_s21 <= div_res.tag.acc;
			app_s21 <= div_res.tag.acc ? div_res.tag.applied : '0;
			drv_s21 <= div_res.tag.acc ? drv_nx : '0;
			dac_s21 <= div_res.tag.acc ? dac_nx : '0;
		end
	end

	assign m_axis_tvalid = vld_s21;
	assign m_axis_tuser  = acc_s21;
	assign m_axis_tdata  = {dac_s21, drv_s21, app_s21};

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`PCAL_ASSERT(a_reject_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "rejected beat carries non-zero data")
	`PCAL_ASSERT_NEXT(a_clamp_accepts, (in_fire && clamp_en_q), acc_s1, "target rejected with clamping on")
	`PCAL_ASSERT_NEXT(a_in_range_kept, (in_fire && s_axis_tdata >= min_dbm_q && s_axis_tdata <= max_dbm_q), (acc_s1 && t_s1 == $past(s_axis_tdata)), "in-range target altered or rejected")

endmodule

### hdl/pcal_prep.sv
module pcal_prep #(
	parameter int CAL_POINTS = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcal_pkg::point_t        pts [CAL_POINTS],
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_acc,
	input  logic [pcal_pkg::DbmW-1:0] in_t,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pcal_pkg::div_job_t      out_job
);

	logic [CAL_POINTS-2:0] hit;
	pcal_pkg::point_t      lo_pt, hi_pt;

	logic                                vld_s2, vld_s3, vld_s4;
	logic                                rdy_s2, rdy_s3, rdy_s4;
	logic                                acc_s2, acc_s3;
	logic [pcal_pkg::DbmW-1:0]           t_s2, t_s3;
	logic signed [pcal_pkg::DiffW-1:0]   dx_s2, span_s2, dyd_s2, dya_s2, span_s3;
	logic [pcal_pkg::DbmW-1:0]           y0d_s2, y0a_s2, y0d_s3, y0a_s3;
	logic signed [pcal_pkg::ProdW-1:0]   prodd_s3, proda_s3;
	pcal_pkg::div_job_t                  job_s4;

	logic signed [pcal_pkg::ProdW-1:0]   magd, maga;
	logic signed [pcal_pkg::DiffW-1:0]   span_mag;

	// First enclosing segment wins; with none, the outer points are used.
	for (genvar i = 0; i < CAL_POINTS - 1; i++) begin : g_hit
		assign hit[i] = (in_t >= pts[i].out_dbm) && (in_t <= pts[i+1].out_dbm);
	end

	always_comb begin
		lo_pt = pts[0];
		hi_pt = pts[CAL_POINTS-1];
		for (int i = CAL_POINTS - 2; i >= 0; i--) begin
			if (hit[i]) begin
				lo_pt = pts[i];
				hi_pt = pts[i+1];
			end
		end
	end

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s2) vld_s2 <= in_valid;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// Segment selection and differences.
	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			acc_s2  <= in_acc;
			t_s2    <= in_t;
			dx_s2   <= $signed({1'b0, in_t}) - $signed({1'b0, lo_pt.out_dbm});
			span_s2 <= $signed({1'b0, hi_pt.out_dbm}) - $signed({1'b0, lo_pt.out_dbm});
			dyd_s2  <= $signed({hi_pt.drive[7], hi_pt.drive}) -
			           $signed({lo_pt.drive[7], lo_pt.drive});
			dya_s2  <= $signed({1'b0, hi_pt.dac}) - $signed({1'b0, lo_pt.dac});
			y0d_s2  <= lo_pt.drive;
			y0a_s2  <= lo_pt.dac;
		end
	end

	// Products of offset and rise.
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			acc_s3   <= acc_s2;
			t_s3     <= t_s2;
			prodd_s3 <= dx_s2 * dyd_s2;
			proda_s3 <= dx_s2 * dya_s2;
			span_s3  <= span_s2;
			y0d_s3   <= y0d_s2;
			y0a_s3   <= y0a_s2;
		end
	end

	// Sign and magnitude split ahead of the unsigned divider.
	assign magd     = prodd_s3[pcal_pkg::ProdW-1] ? -prodd_s3 : prodd_s3;
	assign maga     = proda_s3[pcal_pkg::ProdW-1] ? -proda_s3 : proda_s3;
	assign span_mag = span_s3[pcal_pkg::DiffW-1] ? -span_s3 : span_s3;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			job_s4.tag.acc       <= acc_s3;
			job_s4.tag.applied   <= t_s3;
			job_s4.tag.y0_drive  <= y0d_s3;
			job_s4.tag.y0_dac    <= y0a_s3;
			job_s4.tag.flat      <= (span_s3 == '0);
			job_s4.tag.neg_drive <= prodd_s3[pcal_pkg::ProdW-1] ^ span_s3[pcal_pkg::DiffW-1];
			job_s4.tag.neg_dac   <= proda_s3[pcal_pkg::ProdW-1] ^ span_s3[pcal_pkg::DiffW-1];
			job_s4.num_drive     <= magd[pcal_pkg::NumW-1:0];
			job_s4.num_dac       <= maga[pcal_pkg::NumW-1:0];
			job_s4.den           <= span_mag[pcal_pkg::DenW-1:0];
		end
	end

	assign out_valid = vld_s4;
	assign out_job   = job_s4;

endmodule

### hdl/pcal_div.sv
module pcal_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pcal_pkg::div_job_t in_job,
	output logic               out_valid,
	input  logic               out_ready,
	output pcal_pkg::div_res_t out_res
);

	localparam int Depth = pcal_pkg::NumW;
	localparam int RqW   = pcal_pkg::DenW + pcal_pkg::NumW;

	// The word holds the partial remainder above the dividend; quotient bits
	// shift in at the bottom as dividend bits leave at the top.
	function automatic logic [RqW-1:0] div_step(input logic [RqW-1:0] rq,
		input logic [pcal_pkg::DenW-1:0] den);
		logic [pcal_pkg::DenW:0] part;
		logic [pcal_pkg::DenW:0] diff;
		part = rq[RqW-1:pcal_pkg::NumW-1];
		diff = part - {1'b0, den};
		if (part >= {1'b0, den})
			return {diff[pcal_pkg::DenW-1:0], rq[pcal_pkg::NumW-2:0], 1'b1};
		else
			return {part[pcal_pkg::DenW-1:0], rq[pcal_pkg::NumW-2:0], 1'b0};
	endfunction

	logic                          stg_vld_s [Depth];
	logic                          stg_rdy   [Depth];
	pcal_pkg::div_tag_t            stg_tag_s [Depth];
	logic [pcal_pkg::DenW-1:0]     stg_den_s [Depth];
	logic [RqW-1:0]                stg_rqd_s [Depth];
	logic [RqW-1:0]                stg_rqa_s [Depth];

	for (genvar k = 0; k < Depth; k++) begin : g_stage
		logic                      prev_vld;
		pcal_pkg::div_tag_t        prev_tag;
		logic [pcal_pkg::DenW-1:0] prev_den;
		logic [RqW-1:0]            prev_rqd, prev_rqa;
		logic                      next_rdy;

		if (k == 0) begin : g_first
			assign prev_vld = in_valid;
			assign prev_tag = in_job.tag;
			assign prev_den = in_job.den;
			assign prev_rqd = {{pcal_pkg::DenW{1'b0}}, in_job.num_drive};
			assign prev_rqa = {{pcal_pkg::DenW{1'b0}}, in_job.num_dac};
		end else begin : g_next
			assign prev_vld = stg_vld_s[k-1];
			assign prev_tag = stg_tag_s[k-1];
			assign prev_den = stg_den_s[k-1];
			assign prev_rqd = stg_rqd_s[k-1];
			assign prev_rqa = stg_rqa_s[k-1];
		end

		if (k == Depth - 1) begin : g_last
			assign next_rdy = out_ready;
		end else begin : g_mid
			assign next_rdy = stg_rdy[k+1];
		end

		assign stg_rdy[k] = !stg_vld_s[k] || next_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_vld_s[k] <= 1'b0;
			end else if (stg_rdy[k]) begin
				stg_vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[k] && prev_vld) begin
				stg_tag_s[k] <= prev_tag;
				stg_den_s[k] <= prev_den;
				stg_rqd_s[k] <= div_step(prev_rqd, prev_den);
				stg_rqa_s[k] <= div_step(prev_rqa, prev_den);
			end
		end
	end

	assign in_ready          = stg_rdy[0];
	assign out_valid         = stg_vld_s[Depth-1];
	assign out_res.tag       = stg_tag_s[Depth-1];
	assign out_res.quo_drive = stg_rqd_s[Depth-1][pcal_pkg::NumW-1:0];
	assign out_res.quo_dac   = stg_rqa_s[Depth-1][pcal_pkg::NumW-1:0];

endmodule

### sim/pa_power_calibration_interp_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the calibration core. Target beats are fed from a queue by a clocked
// source process and predicted at the moment they are accepted. A clocked sink process compares
// every result beat, field by field, with the oldest prediction. Register writes happen only
// while the core is empty: after reset, and between phases once every result has been checked.
module pa_power_calibration_interp_core_tb;

	localparam int CalPoints   = 6;
	localparam int PipeLatency = 20;      // cycles from target acceptance to result
	localparam int LongHold    = 300;     // one long back-pressure episode on the result side
	localparam int CycleLimit  = 1000000;
	localparam int RandPhases  = 12;
	localparam int PhaseItems  = 125;
	// Index outside the register map: the core must ignore a write to it.
	localparam logic [2:0] RegUnused = 3'd6;

	// One expected result, in the order accepted, applied, drive, DAC code.
	typedef struct packed {
		logic       accepted;
		logic [7:0] applied;
		logic [7:0] drive;
		logic [7:0] dac;
	} setting_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] target_dbm
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // [7:0] applied_dbm, [15:8] drive_dbm, [23:16] dac_code
	logic        m_axis_tuser;         // [0] accepted
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [47:0] cfg_data      = '0;

	// Our own copy of the register file, kept in step with every accepted write.
	logic [47:0] cal_pair [0:2];
	logic [7:0]  min_dbm;
	logic [7:0]  max_dbm;
	logic        clamp_on;

	logic [7:0] target_q [$];    // targets waiting to be offered
	setting_t   setting_q [$];   // predicted results, oldest first

	int n_bad       = 0;
	int n_results   = 0;
	int n_cycles    = 0;
	int src_wait    = 0;
	int src_quiet   = 0;
	int sink_wait   = 0;
	int sink_quiet  = 0;
	int stall_left  = 0;
	bit stall_done  = 1'b0;

	pa_power_calibration_interp_core #(
		.CAL_POINTS(CalPoints)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic pcal_pkg::point_t cal_point(int idx);
		logic [47:0] pr;
		pr = cal_pair[idx / 2];
		return (idx % 2) ? pcal_pkg::point_t'(pr[47:24]) : pcal_pkg::point_t'(pr[23:0]);
	endfunction

	// Straight line through (x0, y0) and (x1, y1), with the quotient truncated towards zero.
	// A segment of zero width simply yields its lower point.
	function automatic int lerp(int x, int x0, int x1, int y0, int y1);
		if (x1 == x0)
			return y0;
		return y0 + ((x - x0) * (y1 - y0)) / (x1 - x0);
	endfunction

	function automatic setting_t calibrate(logic [7:0] target);
		setting_t         r;
		int               t;
		int               lo;
		int               hi;
		int               i;
		int               drv;
		int               code;
		bit               found;
		pcal_pkg::point_t p0;
		pcal_pkg::point_t p1;
		r = '0;
		t = int'(target);
		// The lower bound is checked first, so with min above max a clamped target ends up at max.
		if (t < int'(min_dbm)) begin
			if (!clamp_on)
				return r;
			t = int'(min_dbm);
		end
		if (t > int'(max_dbm)) begin
			if (!clamp_on)
				return r;
			t = int'(max_dbm);
		end
		// First segment that encloses the target; failing that, the line through the outer points.
		lo = 0;
		hi = CalPoints - 1;
		found = 1'b0;
		for (i = 0; i + 1 < CalPoints; i++) begin
			p0 = cal_point(i);
			p1 = cal_point(i + 1);
			if (!found && t >= int'(p0.out_dbm) && t <= int'(p1.out_dbm)) begin
				lo = i;
				hi = i + 1;
				found = 1'b1;
			end
		end
		p0 = cal_point(lo);
		p1 = cal_point(hi);
		drv = lerp(t, int'(p0.out_dbm), int'(p1.out_dbm), int'($signed(p0.drive)),
			int'($signed(p1.drive)));
		code = lerp(t, int'(p0.out_dbm), int'(p1.out_dbm), int'(p0.dac), int'(p1.dac));
		r.accepted = 1'b1;
		r.applied  = t[7:0];
		r.drive    = drv[7:0];
		r.dac      = code[7:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Idle patterns
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one, and occasional quiet stretches with none at all.
	function automatic int next_idle(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet = $urandom_range(40, 200);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Target source
	// ------------------------------------------------------------------

	// A beat that is accepted is predicted at once, against the registers as they stand. A beat
	// on offer is held until it is taken; only then may a gap or the next target follow.
	always @(posedge clk) begin : target_source
		if (s_axis_tvalid && s_axis_tready)
			setting_q.push_back(calibrate(s_axis_tdata));
		if (s_axis_tvalid && !s_axis_tready) begin
			// Still waiting for the core to take the current beat.
		end else if (src_wait > 0) begin
			src_wait--;
			s_axis_tvalid <= 1'b0;
		end else if (target_q.size() != 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= target_q.pop_front();
			src_wait = next_idle(src_quiet);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result sink and checker
	// ------------------------------------------------------------------

	task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
		$display("%0t ns: %s expected %02h, got %02h", $time, name, want, got);
		n_bad++;
	endtask

	always @(posedge clk) begin : result_sink
		setting_t want;
		setting_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.accepted = m_axis_tuser;
			got.applied  = m_axis_tdata[7:0];
			got.drive    = m_axis_tdata[15:8];
			got.dac      = m_axis_tdata[23:16];
			n_results++;
			if (setting_q.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, got %07h", $time, got);
				n_bad++;
			end else begin
				want = setting_q.pop_front();
				if (got.accepted !== want.accepted)
					report_field("accepted", 8'(want.accepted), 8'(got.accepted));
				if (got.applied !== want.applied)
					report_field("applied_dbm", want.applied, got.applied);
				if (got.drive !== want.drive)
					report_field("drive_dbm", want.drive, got.drive);
				if (got.dac !== want.dac)
					report_field("dac_code", want.dac, got.dac);
			end
			sink_wait = next_idle(sink_quiet);
		end
		// One long hold-off, started while plenty of targets are still queued, so that the
		// pipeline fills completely and the core has to push back on its input.
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!stall_done && n_results >= 200 && target_q.size() > 40) begin
			stall_done = 1'b1;
			stall_left = LongHold;
			m_axis_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles++;
		if (n_cycles >= CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Register access and phase control
	// ------------------------------------------------------------------

	// Must be called just after a rising edge. The caller lowers cfg_valid after the last write,
	// so that valid never drops and rises within one time step between back-to-back writes.
	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			pcal_pkg::REG_CAL_PAIR_0:  cal_pair[0] = val;
			pcal_pkg::REG_CAL_PAIR_1:  cal_pair[1] = val;
			pcal_pkg::REG_CAL_PAIR_2:  cal_pair[2] = val;
			pcal_pkg::REG_MIN_OUT_DBM: min_dbm = val[7:0];
			pcal_pkg::REG_MAX_OUT_DBM: max_dbm = val[7:0];
			pcal_pkg::REG_CLAMP_EN:    clamp_on = val[0];
			default: ;
		endcase
	endtask

	function automatic pcal_pkg::point_t pt(int o, int d, int c);
		pcal_pkg::point_t p;
		p.out_dbm = o[7:0];
		p.drive   = d[7:0];
		p.dac     = c[7:0];
		return p;
	endfunction

	// Sampled on the falling edge so that nothing racing at the rising edge can fool it.
	task automatic wait_idle();
		@(negedge clk);
		while (target_q.size() != 0 || s_axis_tvalid || setting_q.size() != 0)
			@(negedge clk);
		// Let the pipeline settle fully before any register is touched.
		repeat (PipeLatency) @(posedge clk);
	endtask

	// A random set of registers. Most tables are well formed (output powers rising), some have
	// repeated output powers and a few are raw noise. The first phases pin the bounds to extremes.
	task automatic rand_config(int ph);
		logic [47:0]      pr [0:2];
		pcal_pkg::point_t p;
		int               style;
		int               o;
		int               k;
		int               lo_v;
		int               hi_v;
		int               r;
		style = $urandom_range(0, 9);
		o = $urandom_range(0, 40);
		for (k = 0; k < CalPoints; k++) begin
			if (style < 7) begin
				p = pt(o, $urandom, $urandom);
				o = o + $urandom_range(0, 60);
				if (o > 255)
					o = 255;
			end else if (style < 9) begin
				p = pt(o + 20 * $urandom_range(0, 2), $urandom, $urandom);
			end else begin
				p = pcal_pkg::point_t'(24'($urandom));
			end
			if (k % 2)
				pr[k / 2][47:24] = p;
			else
				pr[k / 2][23:0] = p;
		end
		write_reg(pcal_pkg::REG_CAL_PAIR_0, pr[0]);
		write_reg(pcal_pkg::REG_CAL_PAIR_1, pr[1]);
		write_reg(pcal_pkg::REG_CAL_PAIR_2, pr[2]);
		case (ph)
			0: begin
				lo_v = 0;
				hi_v = 255;
			end
			1: begin
				lo_v = 255;
				hi_v = 0;
			end
			2: begin
				lo_v = 255;
				hi_v = 255;
			end
			default: begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					lo_v = $urandom_range(0, 120);
					hi_v = $urandom_range(lo_v, 255);
				end else if (r < 8) begin
					lo_v = $urandom_range(0, 255);
					hi_v = $urandom_range(0, 255);
				end else begin
					lo_v = 0;
					hi_v = 255;
				end
			end
		endcase
		write_reg(pcal_pkg::REG_MIN_OUT_DBM, 48'(lo_v));
		write_reg(pcal_pkg::REG_MAX_OUT_DBM, 48'(hi_v));
		write_reg(pcal_pkg::REG_CLAMP_EN, (ph == 0 || ph == 2) ? 48'd0 : ((ph == 1) ? 48'd1 :
			48'($urandom_range(0, 1))));
		cfg_valid <= 1'b0;
	endtask

	// Half the targets fall inside the allowed window when minimum does not exceed maximum, some sit
	// on or next to a table point, and the rest are spread over the whole range to exercise clamping and rejection.
	function automatic logic [7:0] pick_target();
		int               r;
		int               v;
		pcal_pkg::point_t p;
		r = $urandom_range(0, 99);
		if (r < 50 && min_dbm <= max_dbm)
			return 8'($urandom_range(int'(min_dbm), int'(max_dbm)));
		if (r < 65) begin
			p = cal_point($urandom_range(0, CalPoints - 1));
			v = int'(p.out_dbm) + $urandom_range(0, 2) - 1;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			return v[7:0];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int ph;
		int i;
		// Reset values of the register file.
		cal_pair[0] = '0;
		cal_pair[1] = '0;
		cal_pair[2] = '0;
		min_dbm  = 8'd20;
		max_dbm  = 8'd30;
		clamp_on = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers as left by reset: an all-zero table, targets clamped into 20..30.
		target_q.push_back(8'd0);
		target_q.push_back(8'd255);
		wait_idle();

		// A rising table, full window, rejection enabled; a write to an unused index is ignored.
		write_reg(pcal_pkg::REG_CAL_PAIR_0, {pt(40, -5, 30), pt(10, -20, 0)});
		write_reg(pcal_pkg::REG_CAL_PAIR_1, {pt(120, 10, 150), pt(80, 0, 90)});
		write_reg(pcal_pkg::REG_CAL_PAIR_2, {pt(250, -128, 200), pt(200, 127, 255)});
		write_reg(pcal_pkg::REG_MIN_OUT_DBM, 48'd0);
		write_reg(pcal_pkg::REG_MAX_OUT_DBM, 48'd255);
		write_reg(pcal_pkg::REG_CLAMP_EN, 48'd0);
		write_reg(RegUnused, {16'($urandom), 32'($urandom)});
		cfg_valid <= 1'b0;
		// Below and above the table (extrapolation), exact points, and points inside segments.
		target_q.push_back(8'd0);
		target_q.push_back(8'd255);
		target_q.push_back(8'd10);
		target_q.push_back(8'd40);
		target_q.push_back(8'd25);
		target_q.push_back(8'd100);
		target_q.push_back(8'd160);
		target_q.push_back(8'd199);
		target_q.push_back(8'd250);
		target_q.push_back(8'd128);
		wait_idle();

		// Rejection just outside both bounds, acceptance right on them.
		write_reg(pcal_pkg::REG_MIN_OUT_DBM, 48'd50);
		write_reg(pcal_pkg::REG_MAX_OUT_DBM, 48'd150);
		cfg_valid <= 1'b0;
		target_q.push_back(8'd49);
		target_q.push_back(8'd50);
		target_q.push_back(8'd150);
		target_q.push_back(8'd151);
		wait_idle();

		// Minimum above maximum with clamping: every target lands on the maximum.
		write_reg(pcal_pkg::REG_MIN_OUT_DBM, 48'd200);
		write_reg(pcal_pkg::REG_MAX_OUT_DBM, 48'd100);
		write_reg(pcal_pkg::REG_CLAMP_EN, 48'd1);
		cfg_valid <= 1'b0;
		target_q.push_back(8'd0);
		target_q.push_back(8'd150);
		target_q.push_back(8'd255);
		wait_idle();

		// Zero-width segments, whose lower point's values are returned unchanged, beside a sloped segment and extrapolation.
		write_reg(pcal_pkg::REG_CAL_PAIR_0, {pt(60, 100, 200), pt(60, 5, 7)});
		write_reg(pcal_pkg::REG_CAL_PAIR_1, {pt(90, 1, 9), pt(90, -1, 3)});
		write_reg(pcal_pkg::REG_CAL_PAIR_2, {pt(90, -77, 44), pt(90, 33, 250)});
		write_reg(pcal_pkg::REG_MIN_OUT_DBM, 48'd0);
		write_reg(pcal_pkg::REG_MAX_OUT_DBM, 48'd255);
		cfg_valid <= 1'b0;
		target_q.push_back(8'd60);
		target_q.push_back(8'd75);
		target_q.push_back(8'd255);
		wait_idle();

		// Every point at the same power and the target outside: the outer line has no width.
		write_reg(pcal_pkg::REG_CAL_PAIR_0, {pt(128, -3, 17), pt(128, 64, 128)});
		write_reg(pcal_pkg::REG_CAL_PAIR_1, {pt(128, 2, 2), pt(128, 2, 2)});
		write_reg(pcal_pkg::REG_CAL_PAIR_2, {pt(128, 9, 9), pt(128, -128, 255)});
		cfg_valid <= 1'b0;
		target_q.push_back(8'd3);
		wait_idle();

		// Random phases, each with fresh registers; the sender pauses until the core is empty.
		for (ph = 0; ph < RandPhases; ph++) begin
			rand_config(ph);
			for (i = 0; i < PhaseItems; i++)
				target_q.push_back(pick_target());
			wait_idle();
		end

		// Allow any stray beat to show up before the verdict.
		repeat (PipeLatency * 2) @(posedge clk);
		if (n_bad == 0 && setting_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
